@@ design/cross_distance_engine_assert.svh @@
// Assertion macros for the cross distance engine.
// Used by the top level; depends on nothing else.
`ifndef CROSS_DISTANCE_ENGINE_ASSERT_SVH
`define CROSS_DISTANCE_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define CDE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication failed");

// Next-cycle implication, disabled during reset
`define CDE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle implication failed");

`endif

@@ design/cde_pkg.sv @@
// Package for the cross distance engine: sizes, function codes, state type.
// Used by cross_distance_engine; depends on nothing.
`default_nettype none

package cde_pkg;

   // Store and coordinate sizing
   localparam int MAX_POINTS = 64;
   localparam int COORD_BITS = 24;
   localparam int INDEX_W    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int COUNT_W    = $clog2(MAX_POINTS + 1);

   // Arithmetic widths: difference, squared sum, root, remainder
   localparam int DIFF_W = COORD_BITS + 1;
   localparam int ROOT_W = DIFF_W;
   localparam int RAD_W  = 2 * DIFF_W;
   localparam int REM_W  = ROOT_W + 3;

   // Port field widths
   localparam int FUNC_W      = 2;
   localparam int FIELD_W     = 24;
   localparam int DIST_W      = 25;
   localparam int REF_INDEX_W = 6;

   // Function codes
   localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } cde_state_type;

endpackage

`default_nettype wire

@@ design/cde_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Standalone; depends on nothing.
`default_nettype none

module cde_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                         clock,
   input  wire logic                                         wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                             wr_data,
   input  wire logic                                         rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/cross_distance_engine.sv @@
// Load and clear leave busy low. A query over n stored points holds busy high through the
// strobe of its last distance: each point passes the RAM read, difference, square, sum,
// then one square-root stage per root bit, and distances leave one a cycle. An empty
// store returns no distance and busy stays low.
// The receiver cannot stall: results leave on rsp_strobe for one cycle each.
// Reset (synchronous, active high) empties the store; point memory is left as is.
`default_nettype none

`include "cross_distance_engine_assert.svh"

module cross_distance_engine (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire logic        [cde_pkg::FUNC_W-1:0]      req_func,
   input  wire logic signed [cde_pkg::FIELD_W-1:0]     req_x_coord,
   input  wire logic signed [cde_pkg::FIELD_W-1:0]     req_y_coord,
   output logic                                        rsp_strobe,
   output logic             [cde_pkg::DIST_W-1:0]      rsp_distance,
   output logic             [cde_pkg::REF_INDEX_W-1:0] rsp_ref_index,
   output logic                                        rsp_last
);

   localparam int CB     = cde_pkg::COORD_BITS;
   localparam int IW     = cde_pkg::INDEX_W;
   localparam int CW     = cde_pkg::COUNT_W;
   localparam int DW     = cde_pkg::DIFF_W;
   localparam int RW     = cde_pkg::ROOT_W;
   localparam int AW     = cde_pkg::RAD_W;
   localparam int MW     = cde_pkg::REM_W;

   // Control state
   cde_pkg::cde_state_type state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [IW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic signed [CB-1:0]   qx_ff, qx_in;
   logic signed [CB-1:0]   qy_ff, qy_in;
   logic                   accept;
   logic                   empty_query;
   logic                   wr_en;
   logic                   issue;
   logic                   issue_last;
   logic                   done;

   // Memory interface
   logic [2*CB-1:0]        wr_data;
   logic [2*CB-1:0]        rd_data;

   // Pipeline: read return, magnitudes, squares
   logic                   rd_vld_ff;
   logic [IW-1:0]          rd_idx_ff;
   logic                   rd_last_ff;
   logic                   mg_vld_ff;
   logic [IW-1:0]          mg_idx_ff;
   logic                   mg_last_ff;
   logic [DW-1:0]          mag_x_ff, mag_x_in;
   logic [DW-1:0]          mag_y_ff, mag_y_in;
   logic                   sq_vld_ff;
   logic [IW-1:0]          sq_idx_ff;
   logic                   sq_last_ff;
   logic [AW-1:0]          sq_x_ff, sq_x_in;
   logic [AW-1:0]          sq_y_ff, sq_y_in;
   logic signed [DW-1:0]   diff_x;
   logic signed [DW-1:0]   diff_y;
   logic signed [CB-1:0]   ref_x;
   logic signed [CB-1:0]   ref_y;

   // Square-root stages; index 0 holds the radicand
   logic                   st_vld_ff  [RW+1];
   logic [IW-1:0]          st_idx_ff  [RW+1];
   logic                   st_last_ff [RW+1];
   logic [AW-1:0]          st_rad_ff  [RW+1];
   logic [MW-1:0]          st_rem_ff  [RW+1];
   logic [RW-1:0]          st_root_ff [RW+1];

   assign accept      = start && !busy;
   assign busy        = (state_ff != cde_pkg::ST_IDLE);
   assign done        = st_vld_ff[RW] && st_last_ff[RW];
   assign empty_query = accept && (req_func == cde_pkg::FUNC_QUERY) && (count_ff == '0);

   // Sequence loads, clears and query read-out
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      rd_ptr_in  = rd_ptr_ff;
      qx_in      = qx_ff;
      qy_in      = qy_ff;
      wr_en      = 1'b0;
      issue      = 1'b0;
      issue_last = (CW'(rd_ptr_ff) + CW'(1)) == count_ff;
      unique case (state_ff)
         cde_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_func)
                  cde_pkg::FUNC_LOAD: begin
                     if (count_ff < CW'(cde_pkg::MAX_POINTS)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  cde_pkg::FUNC_QUERY: begin
                     if (count_ff != '0) begin
                        qx_in     = CB'(req_x_coord);
                        qy_in     = CB'(req_y_coord);
                        rd_ptr_in = '0;
                        state_in  = cde_pkg::ST_ISSUE;
                     end
                  end
                  cde_pkg::FUNC_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         cde_pkg::ST_ISSUE: begin
            issue     = 1'b1;
            rd_ptr_in = rd_ptr_ff + IW'(1);
            if (issue_last) begin
               state_in = cde_pkg::ST_DRAIN;
            end
         end
         cde_pkg::ST_DRAIN: begin
            if (done) begin
               state_in = cde_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cde_pkg::ST_IDLE;
         end
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cde_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff <= rd_ptr_in;
      qx_ff     <= qx_in;
      qy_ff     <= qy_in;
   end

   // Point store; reads only run while busy, so no write can overlap them
   assign wr_data = {CB'(req_x_coord), CB'(req_y_coord)};

   cde_ram #(
      .WIDTH (2 * CB),
      .DEPTH (cde_pkg::MAX_POINTS)
   ) u_point_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   // Differences and their magnitudes
   assign ref_x    = rd_data[2*CB-1:CB];
   assign ref_y    = rd_data[CB-1:0];
   assign diff_x   = DW'(ref_x) - DW'(qx_ff);
   assign diff_y   = DW'(ref_y) - DW'(qy_ff);
   assign mag_x_in = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
   assign mag_y_in = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);

   // Squares
   assign sq_x_in = AW'(mag_x_ff) * AW'(mag_x_ff);
   assign sq_y_in = AW'(mag_y_ff) * AW'(mag_y_ff);

   // Advance valid flags of the front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff    <= 1'b0;
         mg_vld_ff    <= 1'b0;
         sq_vld_ff    <= 1'b0;
         st_vld_ff[0] <= 1'b0;
      end else begin
         rd_vld_ff    <= issue;
         mg_vld_ff    <= rd_vld_ff;
         sq_vld_ff    <= mg_vld_ff;
         st_vld_ff[0] <= sq_vld_ff;
      end
   end

   // Advance payload of the front stages
   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_ptr_ff;
      rd_last_ff    <= issue_last;
      mg_idx_ff     <= rd_idx_ff;
      mg_last_ff    <= rd_last_ff;
      mag_x_ff      <= mag_x_in;
      mag_y_ff      <= mag_y_in;
      sq_idx_ff     <= mg_idx_ff;
      sq_last_ff    <= mg_last_ff;
      sq_x_ff       <= sq_x_in;
      sq_y_ff       <= sq_y_in;
      st_idx_ff[0]  <= sq_idx_ff;
      st_last_ff[0] <= sq_last_ff;
      st_rad_ff[0]  <= AW'(sq_x_ff + sq_y_ff);
      st_rem_ff[0]  <= '0;
      st_root_ff[0] <= '0;
   end

   // Square root, one result bit per stage from the top radicand pair down
   for (genvar k = 0; k < RW; k++) begin : g_sqrt
      logic [MW-1:0] rem_shift;
      logic [MW-1:0] trial;
      logic          take;

      assign rem_shift = {st_rem_ff[k][MW-3:0], st_rad_ff[k][AW-1 -: 2]};
      assign trial     = {1'b0, st_root_ff[k], 2'b01};
      assign take      = rem_shift >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            st_vld_ff[k+1] <= 1'b0;
         end else begin
            st_vld_ff[k+1] <= st_vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         st_idx_ff[k+1]  <= st_idx_ff[k];
         st_last_ff[k+1] <= st_last_ff[k];
         st_rad_ff[k+1]  <= {st_rad_ff[k][AW-3:0], 2'b00};
         st_rem_ff[k+1]  <= take ? (rem_shift - trial) : rem_shift;
         st_root_ff[k+1] <= {st_root_ff[k][RW-2:0], take};
      end
   end

   // Result item straight from the final stage
   assign rsp_strobe    = st_vld_ff[RW];
   assign rsp_distance  = cde_pkg::DIST_W'(st_root_ff[RW]);
   assign rsp_ref_index = cde_pkg::REF_INDEX_W'(st_idx_ff[RW]);
   assign rsp_last      = st_last_ff[RW];

   // Checks
   `CDE_ASSERT_IMPL(a_strobe_busy, clock, reset, rsp_strobe, busy)
   `CDE_ASSERT_NEXT(a_last_idle, clock, reset, rsp_strobe && rsp_last, !busy)
   `CDE_ASSERT_NEXT(a_empty_query, clock, reset, empty_query, !busy)
   `CDE_ASSERT_IMPL(a_read_in_range, clock, reset, rd_vld_ff, CW'(rd_idx_ff) < count_ff)

endmodule

`default_nettype wire
